/* src/acm_pkg.sv */
// acm_pkg: operation codes and fixed field widths of the dictionary matcher
// used by aho_corasick_matcher, no dependencies
package acm_pkg;

    typedef logic [2:0] op_t;

    localparam op_t OP_CLEAR = 3'd0;
    localparam op_t OP_PAT_BYTE = 3'd1;
    localparam op_t OP_PAT_END = 3'd2;
    localparam op_t OP_BUILD = 3'd3;
    localparam op_t OP_TEXT = 3'd4;

    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int ID_W = 4;
    localparam int START_W = 32;
    localparam int OUT_DATA_W = 40;

    typedef logic [ID_W-1:0] id_t;
    typedef logic [START_W-1:0] start_t;

endpackage

/* src/aho_corasick_matcher.sv */
// aho_corasick_matcher: trie build, link build and text scan of a dictionary matcher
// trie, links, pattern sets and lengths in synchronous memories; depends on acm_pkg
//
//   channel  | direction | tdata            | tuser                     | tlast
//   s_axis   | in        | data_byte        | operation, text_start     | -
//   m_axis   | out       | pattern_id, pos  | table_full                | last
//
// text word: a trie lookup, failure steps, then a walk of the output chain that
// emits each match; pattern word: a trie read that may add a node; build: every
// byte value of every node is read, plus the failure walks
// after reset and after a clear word a clearing pass over all NODES*256 entries runs
// one word is worked at a time; a full output register stalls match emission
module aho_corasick_matcher #(
    parameter int NODES = 256,
    parameter int MAX_PATTERNS = 16,
    parameter int POS_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // data_byte
    input  logic [3:0]                      s_axis_tuser,   // operation[2:0], text_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [acm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // pattern_id[3:0], start[35:4]
    output logic                            m_axis_tuser,   // table_full
    output logic                            m_axis_tlast
);
    import acm_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int LW = $clog2(NODES + 1);
    localparam int PCW = $clog2(MAX_PATTERNS + 1);
    localparam int IDW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int GW = NW + 8;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_ADD, ST_END,
        ST_BC_RD, ST_BC_CHK, ST_BW_CHK, ST_BW_FAIL, ST_BL_WR,
        ST_Q_RD, ST_Q_WAIT, ST_F_WAIT,
        ST_S_CHK, ST_S_FAIL,
        ST_E_RD, ST_E_LOAD, ST_E_BIT, ST_E_OUT, ST_E_FIN
    } state_t;

    typedef logic [NW-1:0] node_t;
    typedef logic [MAX_PATTERNS-1:0] pset_t;

    function automatic logic [IDW-1:0] lowest_set(input pset_t v);
        logic [IDW-1:0] r;
        r = '0;
        for (int i = MAX_PATTERNS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = IDW'(i);
            end
        end
        return r;
    endfunction

    // memories
    node_t goto_mem [NODES*256];
    node_t fail_mem [NODES];
    node_t outl_mem [NODES];
    pset_t own_mem [NODES];
    logic [LW-1:0] len_mem [MAX_PATTERNS];
    node_t queue_mem [NODES];

    logic goto_we, fail_we, outl_we, own_we, len_we, queue_we;
    logic [GW-1:0] goto_wa, goto_ra;
    node_t goto_wd, goto_q;
    node_t fail_wa, fail_ra, fail_wd, fail_q;
    node_t outl_wa, outl_wd, outl_q;
    node_t own_wa, own_ra;
    pset_t own_wd, own_q;
    logic [IDW-1:0] len_wa, len_ra;
    logic [LW-1:0] len_wd, len_q;
    node_t queue_wa, queue_wd, queue_q;
    node_t queue_ra_w;

    always_ff @(posedge aclk) begin
        if (goto_we) begin
            goto_mem[goto_wa] <= goto_wd;
        end
        goto_q <= goto_mem[goto_ra];
    end

    always_ff @(posedge aclk) begin
        if (fail_we) begin
            fail_mem[fail_wa] <= fail_wd;
        end
        fail_q <= fail_mem[fail_ra];
    end

    always_ff @(posedge aclk) begin
        if (outl_we) begin
            outl_mem[outl_wa] <= outl_wd;
        end
        outl_q <= outl_mem[own_ra];
    end

    always_ff @(posedge aclk) begin
        if (own_we) begin
            own_mem[own_wa] <= own_wd;
        end
        own_q <= own_mem[own_ra];
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_wa] <= len_wd;
        end
        len_q <= len_mem[len_ra];
    end

    always_ff @(posedge aclk) begin
        if (queue_we) begin
            queue_mem[queue_wa] <= queue_wd;
        end
        queue_q <= queue_mem[queue_ra_w];
    end

    // registers
    state_t state_reg, state_next;
    logic [NW:0] node_cnt_reg, node_cnt_next;
    logic [PCW-1:0] pat_cnt_reg, pat_cnt_next;
    node_t ins_node_reg, ins_node_next;
    logic [LW-1:0] ins_len_reg, ins_len_next;
    logic drop_reg, drop_next;
    logic full_reg, full_next;
    node_t cursor_reg, cursor_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [GW-1:0] clr_reg, clr_next;
    logic [7:0] c_reg, c_next;
    node_t cur_reg, cur_next;
    node_t fcur_reg, fcur_next;
    node_t f_reg, f_next;
    node_t ch_reg, ch_next;
    node_t fl_reg, fl_next;
    node_t nxt_reg, nxt_next;
    logic [NW:0] head_reg, head_next;
    logic [NW:0] tail_reg, tail_next;
    logic [LW-1:0] guard_reg, guard_next;
    pset_t bits_reg, bits_next;
    logic [IDW-1:0] id_reg, id_next;
    logic [RES_CNT_W-1:0] k_reg, k_next;
    logic pend_val_reg, pend_val_next;
    logic [IDW-1:0] pend_id_reg, pend_id_next;
    logic [POS_WIDTH-1:0] pend_pos_reg, pend_pos_next;
    logic mval_reg, mval_next;
    id_t mid_reg, mid_next;
    start_t mpos_reg, mpos_next;
    logic mfull_reg, mfull_next;
    logic mlast_reg, mlast_next;

    assign queue_ra_w = head_reg[NW-1:0];

    logic accept, out_free, adv_c, guard_ok;
    op_t op;
    node_t n_eff, fl_w;
    logic [POS_WIDTH-1:0] new_pos;

    assign op = s_axis_tuser[2:0];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !mval_reg || m_axis_tready;
    assign guard_ok = guard_reg < LW'(NODES);
    assign n_eff = s_axis_tuser[3] ? '0 : cursor_reg;
    assign fl_w = (goto_q == ch_reg) ? '0 : goto_q;
    assign new_pos = pos_reg - POS_WIDTH'(len_q) + POS_WIDTH'(1);

    always_comb begin
        state_next = state_reg;
        node_cnt_next = node_cnt_reg;
        pat_cnt_next = pat_cnt_reg;
        ins_node_next = ins_node_reg;
        ins_len_next = ins_len_reg;
        drop_next = drop_reg;
        full_next = full_reg;
        cursor_next = cursor_reg;
        pos_next = pos_reg;
        clr_next = clr_reg;
        c_next = c_reg;
        cur_next = cur_reg;
        fcur_next = fcur_reg;
        f_next = f_reg;
        ch_next = ch_reg;
        fl_next = fl_reg;
        nxt_next = nxt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        guard_next = guard_reg;
        bits_next = bits_reg;
        id_next = id_reg;
        k_next = k_reg;
        pend_val_next = pend_val_reg;
        pend_id_next = pend_id_reg;
        pend_pos_next = pend_pos_reg;
        mval_next = mval_reg && !m_axis_tready;
        mid_next = mid_reg;
        mpos_next = mpos_reg;
        mfull_next = mfull_reg;
        mlast_next = mlast_reg;

        goto_we = 1'b0;
        goto_wa = {ins_node_reg, c_reg};
        goto_wd = node_cnt_reg[NW-1:0];
        goto_ra = {f_reg, c_reg};
        fail_we = 1'b0;
        fail_wa = ch_reg;
        fail_wd = fl_reg;
        fail_ra = f_reg;
        outl_we = 1'b0;
        outl_wa = ch_reg;
        outl_wd = (own_q != '0) ? fl_reg : outl_q;
        own_we = 1'b0;
        own_wa = node_cnt_reg[NW-1:0];
        own_wd = '0;
        own_ra = f_reg;
        len_we = 1'b0;
        len_wa = pat_cnt_reg[IDW-1:0];
        len_wd = ins_len_reg;
        queue_we = 1'b0;
        queue_wa = tail_reg[NW-1:0];
        queue_wd = ch_reg;
        adv_c = 1'b0;

        case (state_reg)
            ST_CLR: begin
                goto_we = 1'b1;
                goto_wa = clr_reg;
                goto_wd = '0;
                own_we = 1'b1;
                own_wa = clr_reg[GW-1:8];
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
                clr_next = clr_reg + GW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_CLEAR: begin
                            state_next = ST_CLR;
                            clr_next = '0;
                            node_cnt_next = (NW+1)'(1);
                            pat_cnt_next = '0;
                            ins_node_next = '0;
                            ins_len_next = '0;
                            drop_next = 1'b0;
                            full_next = 1'b0;
                            cursor_next = '0;
                            pos_next = '0;
                        end
                        OP_PAT_BYTE: begin
                            if (ins_len_reg < LW'(NODES)) begin
                                ins_len_next = ins_len_reg + LW'(1);
                            end
                            if (drop_reg || pat_cnt_reg >= PCW'(MAX_PATTERNS)) begin
                                drop_next = 1'b1;
                            end else begin
                                goto_ra = {ins_node_reg, s_axis_tdata};
                                c_next = s_axis_tdata;
                                state_next = ST_ADD;
                            end
                        end
                        OP_PAT_END: begin
                            if (ins_len_reg != '0 && !drop_reg
                                    && pat_cnt_reg < PCW'(MAX_PATTERNS)) begin
                                own_ra = ins_node_reg;
                                state_next = ST_END;
                            end else begin
                                if (ins_len_reg != '0) begin
                                    full_next = 1'b1;
                                end
                                ins_node_next = '0;
                                ins_len_next = '0;
                                drop_next = 1'b0;
                            end
                        end
                        OP_BUILD: begin
                            fail_we = 1'b1;
                            fail_wa = '0;
                            fail_wd = '0;
                            outl_we = 1'b1;
                            outl_wa = '0;
                            outl_wd = '0;
                            cur_next = '0;
                            fcur_next = '0;
                            c_next = '0;
                            head_next = '0;
                            tail_next = '0;
                            state_next = ST_BC_RD;
                        end
                        OP_TEXT: begin
                            if (s_axis_tuser[3]) begin
                                pos_next = '0;
                            end
                            goto_ra = {n_eff, s_axis_tdata};
                            c_next = s_axis_tdata;
                            f_next = n_eff;
                            guard_next = '0;
                            state_next = ST_S_CHK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD: begin
                state_next = ST_IDLE;
                if (goto_q != '0) begin
                    ins_node_next = goto_q;
                end else if (node_cnt_reg >= (NW+1)'(NODES)) begin
                    drop_next = 1'b1;
                end else begin
                    goto_we = 1'b1;
                    own_we = 1'b1;
                    ins_node_next = node_cnt_reg[NW-1:0];
                    node_cnt_next = node_cnt_reg + (NW+1)'(1);
                end
            end
            ST_END: begin
                own_we = 1'b1;
                own_wa = ins_node_reg;
                own_wd = own_q | (MAX_PATTERNS'(1) << pat_cnt_reg);
                len_we = 1'b1;
                pat_cnt_next = pat_cnt_reg + PCW'(1);
                ins_node_next = '0;
                ins_len_next = '0;
                drop_next = 1'b0;
                state_next = ST_IDLE;
            end
            ST_BC_RD: begin
                goto_ra = {cur_reg, c_reg};
                state_next = ST_BC_CHK;
            end
            ST_BC_CHK: begin
                if (goto_q == '0 || tail_reg >= (NW+1)'(NODES)) begin
                    adv_c = 1'b1;
                end else begin
                    ch_next = goto_q;
                    f_next = fcur_reg;
                    guard_next = '0;
                    goto_ra = {fcur_reg, c_reg};
                    state_next = ST_BW_CHK;
                end
            end
            ST_BW_CHK: begin
                if (f_reg != '0 && goto_q == '0 && guard_ok) begin
                    state_next = ST_BW_FAIL;
                end else begin
                    fl_next = fl_w;
                    own_ra = fl_w;
                    state_next = ST_BL_WR;
                end
            end
            ST_BW_FAIL: begin
                f_next = fail_q;
                guard_next = guard_reg + LW'(1);
                goto_ra = {fail_q, c_reg};
                state_next = ST_BW_CHK;
            end
            ST_BL_WR: begin
                fail_we = 1'b1;
                outl_we = 1'b1;
                queue_we = 1'b1;
                tail_next = tail_reg + (NW+1)'(1);
                adv_c = 1'b1;
            end
            ST_Q_RD: begin
                head_next = head_reg + (NW+1)'(1);
                state_next = ST_Q_WAIT;
            end
            ST_Q_WAIT: begin
                cur_next = queue_q;
                fail_ra = queue_q;
                state_next = ST_F_WAIT;
            end
            ST_F_WAIT: begin
                fcur_next = fail_q;
                c_next = '0;
                state_next = ST_BC_RD;
            end
            ST_S_CHK: begin
                if (f_reg != '0 && goto_q == '0 && guard_ok) begin
                    state_next = ST_S_FAIL;
                end else begin
                    f_next = (goto_q != '0) ? goto_q : f_reg;
                    cursor_next = (goto_q != '0) ? goto_q : f_reg;
                    guard_next = '0;
                    k_next = '0;
                    state_next = ST_E_RD;
                end
            end
            ST_S_FAIL: begin
                f_next = fail_q;
                guard_next = guard_reg + LW'(1);
                goto_ra = {fail_q, c_reg};
                state_next = ST_S_CHK;
            end
            ST_E_RD: begin
                if (f_reg == '0 || !guard_ok || k_reg >= RES_CNT_W'(MAX_RESULTS)) begin
                    state_next = ST_E_FIN;
                end else begin
                    state_next = ST_E_LOAD;
                end
            end
            ST_E_LOAD: begin
                bits_next = own_q;
                nxt_next = outl_q;
                state_next = ST_E_BIT;
            end
            ST_E_BIT: begin
                if (bits_reg == '0 || k_reg >= RES_CNT_W'(MAX_RESULTS)) begin
                    f_next = nxt_reg;
                    guard_next = guard_reg + LW'(1);
                    state_next = ST_E_RD;
                end else begin
                    id_next = lowest_set(bits_reg);
                    bits_next = bits_reg & ~(MAX_PATTERNS'(1) << lowest_set(bits_reg));
                    state_next = ST_E_OUT;
                end
            end
            ST_E_OUT: begin
                if (!pend_val_reg || out_free) begin
                    if (pend_val_reg) begin
                        mval_next = 1'b1;
                        mid_next = id_t'({{ID_W{1'b0}}, pend_id_reg});
                        mpos_next = start_t'({{START_W{1'b0}}, pend_pos_reg});
                        mfull_next = full_reg;
                        mlast_next = 1'b0;
                    end
                    pend_val_next = 1'b1;
                    pend_id_next = id_reg;
                    pend_pos_next = new_pos;
                    k_next = k_reg + RES_CNT_W'(1);
                    state_next = ST_E_BIT;
                end
            end
            ST_E_FIN: begin
                if (!pend_val_reg || out_free) begin
                    if (pend_val_reg) begin
                        mval_next = 1'b1;
                        mid_next = id_t'({{ID_W{1'b0}}, pend_id_reg});
                        mpos_next = start_t'({{START_W{1'b0}}, pend_pos_reg});
                        mfull_next = full_reg;
                        mlast_next = 1'b1;
                    end
                    pend_val_next = 1'b0;
                    pos_next = pos_reg + POS_WIDTH'(1);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv_c) begin
            if (c_reg == 8'hff) begin
                state_next = (head_reg < tail_next) ? ST_Q_RD : ST_IDLE;
            end else begin
                c_next = c_reg + 8'd1;
                state_next = ST_BC_RD;
            end
        end

        len_ra = id_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            clr_reg <= '0;
            node_cnt_reg <= (NW+1)'(1);
            pat_cnt_reg <= '0;
            ins_node_reg <= '0;
            ins_len_reg <= '0;
            drop_reg <= 1'b0;
            full_reg <= 1'b0;
            cursor_reg <= '0;
            pos_reg <= '0;
            pend_val_reg <= 1'b0;
            mval_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            node_cnt_reg <= node_cnt_next;
            pat_cnt_reg <= pat_cnt_next;
            ins_node_reg <= ins_node_next;
            ins_len_reg <= ins_len_next;
            drop_reg <= drop_next;
            full_reg <= full_next;
            cursor_reg <= cursor_next;
            pos_reg <= pos_next;
            pend_val_reg <= pend_val_next;
            mval_reg <= mval_next;
            c_reg <= c_next;
            cur_reg <= cur_next;
            fcur_reg <= fcur_next;
            f_reg <= f_next;
            ch_reg <= ch_next;
            fl_reg <= fl_next;
            nxt_reg <= nxt_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            guard_reg <= guard_next;
            bits_reg <= bits_next;
            id_reg <= id_next;
            k_reg <= k_next;
            pend_id_reg <= pend_id_next;
            pend_pos_reg <= pend_pos_next;
            mid_reg <= mid_next;
            mpos_reg <= mpos_next;
            mfull_reg <= mfull_next;
            mlast_reg <= mlast_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata = {{(OUT_DATA_W - START_W - ID_W){1'b0}}, mpos_reg, mid_reg};
    assign m_axis_tuser = mfull_reg;
    assign m_axis_tlast = mlast_reg;

endmodule

/* sim/aho_corasick_matcher_tb.sv */
// aho_corasick_matcher_tb: self-checking bench for the dictionary matcher, building
// tries, links and scanning text against a cycle-free predictor of the match stream
// depends on acm_pkg and aho_corasick_matcher
`timescale 1ns / 100ps

module aho_corasick_matcher_tb;
    import acm_pkg::*;

    localparam int NODE_CNT = 256;
    localparam int PAT_CNT = 16;
    localparam int LIMIT = 6000000;
    localparam int TAIL_CYCLES = 1200;

    typedef struct {
        id_t    id;
        start_t start;
        logic   full;
        logic   last;
    } match_t;

    logic            aclk;
    logic            aresetn;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [7:0]      s_axis_tdata;
    logic [3:0]      s_axis_tuser;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic            m_axis_tuser;
    logic            m_axis_tlast;

    aho_corasick_matcher u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // predictor state
    logic [7:0]  trie_next [NODE_CNT][256];
    logic [7:0]  fail_to [NODE_CNT];
    logic [7:0]  out_to [NODE_CNT];
    logic [15:0] ends_here [NODE_CNT];
    int          pat_len [PAT_CNT];
    int          n_nodes, n_pats, ins_node, ins_len, cur_node;
    start_t      text_pos;
    logic        full_seen, dropping;

    match_t      match_q[$];
    int          errors;
    int          send_idle, recv_stall;
    int          hold_req, hold_seen, hold_left;
    int          cycles;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls plus requested long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // result checker
    always @(posedge aclk) begin
        match_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (match_q.size() == 0) begin
                $display("%0t unexpected word exp none act id=%0d start=%0d", $time,
                         m_axis_tdata[3:0], m_axis_tdata[35:4]);
                errors++;
            end else begin
                e = match_q.pop_front();
                if (m_axis_tdata[3:0] !== e.id || m_axis_tdata[35:4] !== e.start ||
                    m_axis_tdata[39:36] !== 4'd0 || m_axis_tuser !== e.full ||
                    m_axis_tlast !== e.last) begin
                    $display("%0t mismatch exp id=%0d start=%0d full=%0b last=%0b",
                             $time, e.id, e.start, e.full, e.last);
                    $display("%0t          act id=%0d start=%0d full=%0b last=%0b",
                             $time, m_axis_tdata[3:0], m_axis_tdata[35:4],
                             m_axis_tuser, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    function automatic void dict_reset();
        for (int n = 0; n < NODE_CNT; n++) begin
            for (int c = 0; c < 256; c++) trie_next[n][c] = 8'd0;
            fail_to[n] = 8'd0;
            out_to[n] = 8'd0;
            ends_here[n] = 16'd0;
        end
        for (int p = 0; p < PAT_CNT; p++) pat_len[p] = 0;
        n_nodes = 1;
        n_pats = 0;
        ins_node = 0;
        ins_len = 0;
        cur_node = 0;
        text_pos = '0;
        full_seen = 1'b0;
        dropping = 1'b0;
    endfunction

    function automatic void dict_add(int c);
        int nx;
        if (ins_len < NODE_CNT) ins_len++;
        if (n_pats >= PAT_CNT) dropping = 1'b1;
        if (dropping) return;
        nx = int'(trie_next[ins_node][c]);
        if (nx == 0) begin
            if (n_nodes >= NODE_CNT) begin
                dropping = 1'b1;
                return;
            end
            nx = n_nodes++;
            fail_to[nx] = 8'd0;
            out_to[nx] = 8'd0;
            ends_here[nx] = 16'd0;
            trie_next[ins_node][c] = 8'(nx);
        end
        ins_node = nx;
    endfunction

    function automatic void dict_end();
        if (ins_len != 0) begin
            if (dropping || n_pats >= PAT_CNT) begin
                full_seen = 1'b1;
            end else begin
                ends_here[ins_node][n_pats] = 1'b1;
                pat_len[n_pats] = ins_len;
                n_pats++;
            end
        end
        ins_node = 0;
        ins_len = 0;
        dropping = 1'b0;
    endfunction

    function automatic void dict_build();
        int bfs [NODE_CNT];
        int head, tail, cur, ch, f, g, fl;
        head = 0;
        tail = 0;
        fail_to[0] = 8'd0;
        out_to[0] = 8'd0;
        for (int c = 0; c < 256; c++) begin
            ch = int'(trie_next[0][c]);
            if (ch != 0 && tail < NODE_CNT) begin
                fail_to[ch] = 8'd0;
                out_to[ch] = 8'd0;
                bfs[tail++] = ch;
            end
        end
        while (head < tail) begin
            cur = bfs[head++];
            for (int c = 0; c < 256; c++) begin
                ch = int'(trie_next[cur][c]);
                if (ch != 0 && tail < NODE_CNT) begin
                    f = int'(fail_to[cur]);
                    g = 0;
                    while (f != 0 && trie_next[f][c] == 0 && g < NODE_CNT) begin
                        f = int'(fail_to[f]);
                        g++;
                    end
                    fl = int'(trie_next[f][c]);
                    if (fl == ch) fl = 0;
                    fail_to[ch] = 8'(fl);
                    out_to[ch] = (ends_here[fl] != 0) ? 8'(fl) : out_to[fl];
                    bfs[tail++] = ch;
                end
            end
        end
    endfunction

    function automatic void dict_scan(int c, bit restart);
        int n, g, k;
        match_t m;
        if (restart) begin
            cur_node = 0;
            text_pos = '0;
        end
        n = cur_node;
        g = 0;
        while (n != 0 && trie_next[n][c] == 0 && g < NODE_CNT) begin
            n = int'(fail_to[n]);
            g++;
        end
        if (trie_next[n][c] != 0) n = int'(trie_next[n][c]);
        cur_node = n;
        k = 0;
        g = 0;
        while (n != 0 && g < NODE_CNT && k < MAX_RESULTS) begin
            for (int id = 0; id < PAT_CNT && k < MAX_RESULTS; id++) begin
                if (ends_here[n][id]) begin
                    m.id = id_t'(id);
                    m.start = text_pos - start_t'(pat_len[id]) + start_t'(1);
                    m.full = full_seen;
                    m.last = 1'b0;
                    match_q = {match_q, m};
                    k++;
                end
            end
            n = int'(out_to[n]);
            g++;
        end
        if (k > 0) match_q[match_q.size() - 1].last = 1'b1;
        text_pos = text_pos + start_t'(1);
    endfunction

    task automatic send_word(op_t op, logic [7:0] d, bit ts);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= {ts, op};
        do @(posedge aclk); while (!s_axis_tready);
        case (op)
            OP_CLEAR:    dict_reset();
            OP_PAT_BYTE: dict_add(int'(d));
            OP_PAT_END:  dict_end();
            OP_BUILD:    dict_build();
            OP_TEXT:     dict_scan(int'(d), ts);
            default: ;
        endcase
    endtask

    task automatic send_pattern(string s);
        for (int i = 0; i < s.len(); i++) send_word(OP_PAT_BYTE, s[i], 1'b0);
        send_word(OP_PAT_END, 8'd0, 1'b0);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(OP_TEXT, s[i], i == 0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (match_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic test_classic();
        send_word(OP_PAT_END, 8'd0, 1'b1);
        send_pattern("he");
        send_pattern("she");
        send_pattern("his");
        send_pattern("hers");
        send_word(OP_PAT_BYTE, 8'h00, 1'b0);
        send_word(OP_PAT_BYTE, 8'hff, 1'b1);
        send_word(OP_PAT_END, 8'd0, 1'b0);
        send_word(op_t'(5), 8'h55, 1'b1);
        send_word(op_t'(6), 8'haa, 1'b0);
        send_word(op_t'(7), 8'hff, 1'b1);
        send_word(OP_BUILD, 8'd0, 1'b0);
        send_text("ushers");
        send_word(OP_TEXT, 8'h00, 1'b0);
        send_word(OP_TEXT, 8'hff, 1'b0);
        send_text("hishe");
        drain();
    endtask

    // four nested 'a' runs, each ending four patterns, then one pattern too many
    task automatic test_result_limit();
        string s;
        send_word(OP_CLEAR, 8'd0, 1'b0);
        for (int i = 0; i < PAT_CNT; i++) begin
            s = "";
            for (int j = 0; j <= i % 4; j++) s = {s, "a"};
            send_pattern(s);
        end
        send_pattern("b");
        send_word(OP_BUILD, 8'd0, 1'b0);
        for (int i = 0; i < 8; i++) send_word(OP_TEXT, "a", i == 0);
        send_word(OP_TEXT, "b", 1'b0);
        drain();
    endtask

    task automatic test_node_overflow();
        send_word(OP_CLEAR, 8'd0, 1'b0);
        send_pattern("xy");
        for (int i = 0; i < 250; i++) send_word(OP_PAT_BYTE, 8'(i), 1'b0);
        send_word(OP_PAT_END, 8'd0, 1'b0);
        for (int i = 0; i < 4; i++) send_word(OP_PAT_BYTE, 8'hf0, 1'b0);
        send_word(OP_PAT_END, 8'd0, 1'b0);
        send_pattern("x");
        send_word(OP_BUILD, 8'd0, 1'b0);
        send_text("xyxx");
        for (int i = 0; i < 3; i++) send_word(OP_TEXT, 8'(i), 1'b0);
        drain();
    endtask

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(15) == 0) return 8'($urandom);
        return 8'("a" + $urandom_range(2));
    endfunction

    task automatic test_random_scan(int idle_s, int stall_r, bit fresh, bit squeeze);
        int len;
        send_idle = idle_s;
        recv_stall = stall_r;
        if (fresh) send_word(OP_CLEAR, 8'd0, 1'b0);
        for (int p = 0; p < 5; p++) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) send_word(OP_PAT_BYTE, pick_letter(), 1'($urandom));
            send_word(OP_PAT_END, 8'($urandom), 1'($urandom));
        end
        send_word(OP_BUILD, 8'($urandom), 1'($urandom));
        if (squeeze) hold_req++;
        for (int i = 0; i < 15; i++) begin
            if ($urandom_range(9) == 0)
                send_word(op_t'($urandom_range(5, 7)), 8'($urandom), 1'($urandom));
            send_word(OP_TEXT, pick_letter(), $urandom_range(19) == 0);
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        cycles = 0;
        dict_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_classic();
        test_result_limit();
        test_node_overflow();
        test_random_scan(0, 0, 1'b1, 1'b1);
        test_random_scan(54, 0, 1'b0, 1'b0);
        test_random_scan(0, 54, 1'b1, 1'b0);
        test_random_scan(12, 12, 1'b0, 1'b1);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
